[hw/rtl/lfbd_pkg.sv]
// Shared types and constants of the LZSS flag-byte decompressor.
package lfbd_pkg;

  localparam int unsigned HistAw    = 12;
  localparam int unsigned HistDepth = 1 << HistAw;
  localparam int unsigned LenW      = 5;
  localparam int unsigned DistW     = HistAw + 1;
  localparam int unsigned CfgW      = 24;

  localparam logic [3:0] TokensPerFlag = 4'd8;
  localparam logic [3:0] LenFieldMask  = 4'hF;

  // configuration register indexes
  localparam logic CfgIdxSize = 1'b0;
  localparam logic CfgIdxMode = 1'b1;

  // classification of the byte at the input
  typedef enum logic [2:0] {
    KIND_START,
    KIND_IGNORE,
    KIND_FLAG,
    KIND_LITERAL,
    KIND_PAIR_LOW,
    KIND_PAIR_HIGH
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic take;        // input transfer this cycle
    logic rd_en;       // read history for the next copied byte
    logic emit_copy;   // emit the copied byte and record it
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_e kind;
    logic  out_free;
    logic  copy_last;
  } stat_t;

endpackage

[hw/rtl/lfbd_ctrl.sv]
// Controller state machine: input transfers and match copy sequencing.
module lfbd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lfbd_pkg::stat_t stat_i,
  output lfbd_pkg::cmd_t  cmd_o
);
  import lfbd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    in_ready_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = stat_i.out_free;
        if (in_valid_i && stat_i.out_free) begin
          cmd_o.take = 1'b1;
          if (stat_i.kind == KIND_PAIR_HIGH) begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_WRITE;
      end
      ST_WRITE: begin
        // hold the read data until the output register frees up
        if (stat_i.out_free) begin
          cmd_o.emit_copy = 1'b1;
          state_d = stat_i.copy_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/lfbd_dpath.sv]
// Datapath: token parsing state, counters, history memory and output register.
module lfbd_dpath #(
  parameter int unsigned SIZE_BITS = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [lfbd_pkg::CfgW-1:0]  cfg_wdata_i,
  input  logic                       in_first_i,
  input  logic [7:0]                 in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 out_byte_o,
  output logic                       out_run_last_o,
  output logic                       out_stream_last_o,
  input  lfbd_pkg::cmd_t             cmd_i,
  output lfbd_pkg::stat_t            stat_o
);
  import lfbd_pkg::*;

  // configuration
  logic [CfgW-1:0] size_q, size_d;
  logic [1:0]      mode_q, mode_d;

  // parsing state
  logic [7:0]           flag_q, flag_d;
  logic [3:0]           tokens_q, tokens_d;
  logic                 pending_q, pending_d;
  logic [7:0]           low_q, low_d;
  logic [SIZE_BITS-1:0] rem_q, rem_d;
  logic [DistW-1:0]     produced_q, produced_d;
  logic [HistAw-1:0]    wp_q, wp_d;
  logic                 finished_q, finished_d;

  // match copy
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  cnt_q, cnt_d;
  logic [DistW-1:0] dist_q, dist_d;

  // output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_run_q, out_run_d;
  logic       out_slast_q, out_slast_d;

  // history
  logic [7:0]        hist_mem [HistDepth];
  logic [7:0]        rdata_q;
  logic [HistAw-1:0] rd_addr;

  kind_e                kind;
  logic                 out_free;
  logic                 copy_last;
  logic                 emit_lit;
  logic                 emit;
  logic [7:0]           emit_byte;
  logic                 emit_run;
  logic                 rem_one;
  logic [31:0]          size_ext;
  logic [SIZE_BITS-1:0] rem_load;
  logic [1:0]           mode_eff;

  assign size_ext = {{(32 - CfgW){1'b0}}, size_q};
  assign rem_load = size_ext[SIZE_BITS-1:0];
  assign rem_one  = (rem_q == SIZE_BITS'(1));
  assign out_free = !out_valid_q || out_ready_i;
  assign mode_eff = (mode_q == 2'd3) ? 2'd2 : mode_q;
  assign rd_addr  = wp_q - dist_q[HistAw-1:0];

  always_comb begin
    if (in_first_i) begin
      kind = KIND_START;
    end else if (finished_q) begin
      kind = KIND_IGNORE;
    end else if (tokens_q == 4'd0) begin
      kind = KIND_FLAG;
    end else if (flag_q[0]) begin
      kind = KIND_LITERAL;
    end else if (!pending_q) begin
      kind = KIND_PAIR_LOW;
    end else begin
      kind = KIND_PAIR_HIGH;
    end
  end

  assign copy_last = ((cnt_q + LenW'(1)) == len_q) || rem_one;

  assign stat_o.kind      = kind;
  assign stat_o.out_free  = out_free;
  assign stat_o.copy_last = copy_last;

  assign emit_lit  = cmd_i.take && (kind == KIND_LITERAL);
  assign emit      = emit_lit || cmd_i.emit_copy;
  assign emit_run  = emit_lit || copy_last;
  // reads reaching before the stream start give zero
  assign emit_byte = emit_lit ? in_data_i :
                     ((dist_q <= produced_q) ? rdata_q : 8'h00);

  always_comb begin
    size_d      = size_q;
    mode_d      = mode_q;
    flag_d      = flag_q;
    tokens_d    = tokens_q;
    pending_d   = pending_q;
    low_d       = low_q;
    rem_d       = rem_q;
    produced_d  = produced_q;
    wp_d        = wp_q;
    finished_d  = finished_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    dist_d      = dist_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    out_run_d   = out_run_q;
    out_slast_d = out_slast_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgIdxSize: size_d = cfg_wdata_i;
        CfgIdxMode: mode_d = cfg_wdata_i[1:0];
        default: ;
      endcase
    end

    if (cmd_i.take) begin
      case (kind)
        KIND_START: begin
          rem_d      = rem_load;
          produced_d = '0;
          wp_d       = '0;
          pending_d  = 1'b0;
          low_d      = 8'h00;
          flag_d     = in_data_i;
          tokens_d   = TokensPerFlag;
          finished_d = (rem_load == '0);
        end
        KIND_FLAG: begin
          flag_d   = in_data_i;
          tokens_d = TokensPerFlag;
        end
        KIND_LITERAL: begin
          flag_d   = {1'b0, flag_q[7:1]};
          tokens_d = tokens_q - 4'd1;
        end
        KIND_PAIR_LOW: begin
          low_d     = in_data_i;
          pending_d = 1'b1;
        end
        KIND_PAIR_HIGH: begin
          pending_d = 1'b0;
          len_d     = {1'b0, low_q[3:0] & LenFieldMask} + {3'b000, mode_eff} + LenW'(1);
          dist_d    = {1'b0, in_data_i, low_q[7:4]} + DistW'(1);
          cnt_d     = '0;
          flag_d    = {1'b0, flag_q[7:1]};
          tokens_d  = tokens_q - 4'd1;
        end
        default: ;
      endcase
    end

    if (cmd_i.emit_copy) begin
      cnt_d = cnt_q + LenW'(1);
    end

    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = emit_byte;
      out_run_d   = emit_run;
      out_slast_d = rem_one;
      wp_d        = wp_q + HistAw'(1);
      if (produced_q < DistW'(HistDepth)) begin
        produced_d = produced_q + DistW'(1);
      end
      rem_d = rem_q - SIZE_BITS'(1);
      if (rem_one) begin
        finished_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= CfgW'(1);
      mode_q      <= 2'd1;
      flag_q      <= 8'h00;
      tokens_q    <= 4'd0;
      pending_q   <= 1'b0;
      rem_q       <= '0;
      produced_q  <= '0;
      wp_q        <= '0;
      finished_q  <= 1'b1;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      size_q      <= size_d;
      mode_q      <= mode_d;
      flag_q      <= flag_d;
      tokens_q    <= tokens_d;
      pending_q   <= pending_d;
      rem_q       <= rem_d;
      produced_q  <= produced_d;
      wp_q        <= wp_d;
      finished_q  <= finished_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q       <= low_d;
    len_q       <= len_d;
    dist_q      <= dist_d;
    out_byte_q  <= out_byte_d;
    out_run_q   <= out_run_d;
    out_slast_q <= out_slast_d;
  end

  // history memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (emit) begin
      hist_mem[wp_q] <= emit_byte;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= hist_mem[rd_addr];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_byte_o        = out_byte_q;
  assign out_run_last_o    = out_run_q;
  assign out_stream_last_o = out_slast_q;

`ifndef NO_ASSERTIONS
  a_produced_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    produced_q <= DistW'(HistDepth))
    else $error("produced count above history depth");

  a_active_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !finished_q |-> (rem_q != '0))
    else $error("stream active with no bytes remaining");

  a_literal_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_lit |=> (out_valid_q && out_run_q && (out_byte_q == $past(in_data_i))))
    else $error("literal not presented at output");

  a_copy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_copy |-> (cnt_q < len_q))
    else $error("match copy ran past its length");
`endif

endmodule

[hw/rtl/lzss_flag_byte_decompressor.sv]
// Top level of the LZSS flag-byte decompressor.
//
//  channel   direction  tdata          tuser             tlast
//  s_axis    in         data_byte[7:0] first_of_stream   -
//  m_axis    out        out_byte[7:0]  run_last          stream_last
//  cfg       in         index 0: decompressed_size, index 1: length_mode
//
// A flag byte, a pair low byte or a literal is a single input transfer; a
// match takes its high byte, then per copied byte a history read state and
// an output and history write state, for 1 to 18 copied bytes.
// Each copied byte is read only after the byte before it is written back,
// which sets the copy rate.
// Input stalls while a match is copied or the output register is full.
// Reset leaves the history uncleared; reads before the stream start give zero.
module lzss_flag_byte_decompressor #(
  parameter int unsigned SIZE_BITS = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [lfbd_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] data_byte
  input  logic                      s_axis_tuser,   // [0] first_of_stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,   // [7:0] out_byte
  output logic                      m_axis_tuser,   // [0] run_last
  output logic                      m_axis_tlast    // stream_last
);
  import lfbd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lfbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lfbd_dpath #(
    .SIZE_BITS (SIZE_BITS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_first_i        (s_axis_tuser),
    .in_data_i         (s_axis_tdata),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .out_byte_o        (m_axis_tdata),
    .out_run_last_o    (m_axis_tuser),
    .out_stream_last_o (m_axis_tlast),
    .cmd_i             (cmd),
    .stat_o            (stat)
  );

endmodule
